FILE: rtl/assert_macros.svh
// Assertion macros for the RTL of the scorer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME_CYCLE(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT_CYCLE(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/lrs_pkg.sv
// Types, constants and elaboration helpers of the logistic regression scorer.
`timescale 1ns / 1ps
package lrs_pkg;

	localparam int INDEX_W     = 8;
	localparam int VALUE_W     = 24;
	localparam int DIFF_W      = VALUE_W + 1;
	localparam int INV_W       = 32;
	localparam int PROD_W      = DIFF_W + INV_W + 1;
	localparam int LIMIT_W     = 23;
	localparam int NORM_SHIFT  = 16;
	localparam int TERM_PROD_W = 2 * VALUE_W;
	localparam int TERM_W      = TERM_PROD_W - NORM_SHIFT;
	localparam int ACC_W       = 48;
	localparam int PROB_W      = 16;
	localparam int TP_W        = 22;

	localparam logic [LIMIT_W-1:0] NORM_LIMIT_RESET  = 23'd655360;
	localparam logic [LIMIT_W-1:0] SCORE_LIMIT_RESET = 23'd1310720;

	localparam longint          TABLE_HALF_RANGE = 64'sd2097152;
	localparam longint unsigned Q31_ONE          = 64'd2147483648;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		FUNC_LOAD     = 2'd0,
		FUNC_BIAS     = 2'd1,
		FUNC_SAMPLE   = 2'd2,
		FUNC_RESERVED = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_BIAS   = 2'd1,
		OP_SAMPLE = 2'd2
	} op_t;

	typedef enum logic {
		CFG_NORMALIZED_LIMIT = 1'b0,
		CFG_SCORE_LIMIT      = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		func_t                     func;
		logic [INDEX_W-1:0]        feature_index;
		logic signed [VALUE_W-1:0] feature_value;
		logic signed [VALUE_W-1:0] feature_mean;
		logic [INV_W-1:0]          inverse_scale;
		logic signed [VALUE_W-1:0] weight;
		logic                      last_feature;
	} item_t;

	typedef struct packed {
		logic [PROB_W-1:0]         probability;
		logic signed [VALUE_W-1:0] clamped_score;
		logic                      score_saturated;
	} result_t;

	typedef struct packed {
		cfg_reg_t           index;
		logic [LIMIT_W-1:0] value;
	} cfg_req_t;

	// Classified request handed from the front end to the back end.
	typedef struct packed {
		op_t                       op;
		logic                      in_range;
		logic                      first;
		logic                      last;
		logic [INDEX_W-1:0]        index;
		logic signed [VALUE_W-1:0] value;
		logic signed [VALUE_W-1:0] mean;
		logic [INV_W-1:0]          inv_scale;
		logic signed [VALUE_W-1:0] weight;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic result_pending;
	} back_status_t;

	// Unsigned long division by shift and subtract, used only at elaboration.
	function automatic longint unsigned udiv(input longint unsigned num,
		input longint unsigned den);
		longint unsigned quo;
		logic [64:0]     rem;
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			if (rem >= {1'b0, den}) begin
				rem    = rem - {1'b0, den};
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// e to the power -a, a in Q16 up to 32.0, result in Q31. A short series on a/256
	// followed by eight rounded squarings.
	function automatic longint unsigned exp_neg(input longint unsigned a);
		longint unsigned u;
		longint unsigned u2;
		longint unsigned u3;
		longint unsigned u4;
		longint unsigned r;
		u  = a << 7;
		u2 = (u * u) >> 31;
		u3 = (u2 * u) >> 31;
		u4 = (u3 * u) >> 31;
		r  = (Q31_ONE + u2 / 2 + u4 / 24) - u - u3 / 6;
		for (int k = 0; k < 8; k++) begin
			r = (r * r + 64'd1073741824) >> 31;
		end
		return r;
	endfunction

endpackage

FILE: rtl/lrs_stream_if.sv
// Valid/ready channel with a typed payload.
`timescale 1ns / 1ps
interface lrs_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/lrs_queue.sv
// Short request queue between the front end and the back end.
`timescale 1ns / 1ps
module lrs_queue (
	input logic         clk,
	input logic         arst_n,
	lrs_stream_if.sink   push,
	lrs_stream_if.source pop
);
	import lrs_pkg::*;

	cmd_t              fifo_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign push.ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign pop.valid  = (count_q != '0);
	assign pop.data   = fifo_q[rd_ptr_q];
	assign do_push    = push.valid && push.ready;
	assign do_pop     = pop.valid && pop.ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			fifo_q[wr_ptr_q] <= push.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

FILE: rtl/lrs_front.sv
// Front end: accepts input requests, classifies them and drops those that do nothing.
`timescale 1ns / 1ps
module lrs_front #(
	parameter int MAX_FEATURES = 256
) (
	input logic         clk,
	input logic         arst_n,
	lrs_stream_if.sink   samples,
	lrs_stream_if.source push
);
	import lrs_pkg::*;

	cmd_t cmd_s1;
	logic valid_s1;
	cmd_t cmd_c;
	logic keep_c;
	logic take;

	assign samples.ready = !valid_s1 || push.ready;
	assign take          = samples.valid && samples.ready;
	assign push.valid    = valid_s1;
	assign push.data     = cmd_s1;

	always_comb begin
		cmd_c.in_range  = (32'(samples.data.feature_index) < MAX_FEATURES);
		cmd_c.first     = (samples.data.feature_index == '0);
		cmd_c.last      = samples.data.last_feature;
		cmd_c.index     = samples.data.feature_index;
		cmd_c.value     = samples.data.feature_value;
		cmd_c.mean      = samples.data.feature_mean;
		cmd_c.inv_scale = samples.data.inverse_scale;
		cmd_c.weight    = samples.data.weight;
		cmd_c.op        = OP_SAMPLE;
		keep_c          = 1'b0;
		unique case (samples.data.func)
			FUNC_LOAD: begin
				// Loads past the end of the tables have no effect.
				cmd_c.op = OP_LOAD;
				keep_c   = cmd_c.in_range;
			end
			FUNC_BIAS: begin
				cmd_c.op = OP_BIAS;
				keep_c   = 1'b1;
			end
			FUNC_SAMPLE: begin
				cmd_c.op = OP_SAMPLE;
				keep_c   = 1'b1;
			end
			FUNC_RESERVED: begin
				keep_c = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= take && keep_c;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= cmd_c;
		end
	end
endmodule

FILE: rtl/lrs_back.sv
// Back end: coefficient tables, standardize and multiply pipeline, accumulator, sigmoid lookup.
`timescale 1ns / 1ps
module lrs_back #(
	parameter int MAX_FEATURES    = 256,
	parameter int SIGMOID_ENTRIES = 1024
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic [lrs_pkg::LIMIT_W-1:0]    normalized_limit,
	input logic [lrs_pkg::LIMIT_W-1:0]    score_limit,
	lrs_stream_if.sink                     cmds,
	lrs_stream_if.source                   scores,
	output lrs_pkg::back_status_t          status
);
	import lrs_pkg::*;

	localparam int AddrW    = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
	localparam int RomAw    = (SIGMOID_ENTRIES > 1) ? $clog2(SIGMOID_ENTRIES) : 1;
	localparam int EntW     = $clog2(SIGMOID_ENTRIES + 1);
	localparam int TiProdW  = TP_W + EntW;
	localparam longint SigSpan = 2 * longint'(SIGMOID_ENTRIES);
	localparam logic signed [VALUE_W-1:0] HalfPos = VALUE_W'(TABLE_HALF_RANGE);
	localparam logic signed [VALUE_W-1:0] HalfNeg = -HalfPos;
	localparam logic signed [VALUE_W-1:0] HalfTop = HalfPos - 1'b1;

	typedef logic [PROB_W-1:0] sig_rom_t [SIGMOID_ENTRIES];

	typedef struct packed {
		op_t                       op;
		logic                      in_range;
		logic                      first;
		logic                      last;
		logic signed [VALUE_W-1:0] value;
	} ctl_t;

	// Sigmoid at the middle of table interval idx, rounded to Q0.16 and saturated.
	function automatic logic [PROB_W-1:0] sig_point(input int idx);
		longint          x;
		longint unsigned a;
		longint unsigned e;
		longint unsigned d;
		longint unsigned num;
		longint unsigned p;
		x   = -TABLE_HALF_RANGE
			+ ((2 * longint'(idx) + 1) * (2 * TABLE_HALF_RANGE)) / SigSpan;
		a   = (x < 0) ? longint'(-x) : longint'(x);
		e   = exp_neg(a);
		d   = Q31_ONE + e;
		num = (x > 0) ? (64'd1 << 47) : (e << 16);
		p   = udiv(num + (d >> 1), d);
		return (p > 64'd65535) ? {PROB_W{1'b1}} : p[PROB_W-1:0];
	endfunction

	function automatic sig_rom_t build_rom();
		sig_rom_t rom;
		for (int i = 0; i < SIGMOID_ENTRIES; i++) begin
			rom[i] = sig_point(i);
		end
		return rom;
	endfunction

	localparam sig_rom_t SigRom = build_rom();

	logic signed [VALUE_W-1:0] mean_mem [MAX_FEATURES];
	logic [INV_W-1:0]          inv_mem  [MAX_FEATURES];
	logic signed [VALUE_W-1:0] coef_mem [MAX_FEATURES];

	logic adv;
	logic pop;
	logic [AddrW-1:0] addr;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7, valid_s8;
	logic out_valid_q;
	ctl_t tag_s1, tag_s2, tag_s3, tag_s4, tag_s5;

	logic signed [VALUE_W-1:0] mean_rd_s1;
	logic [INV_W-1:0]          inv_rd_s1;
	logic signed [VALUE_W-1:0] coef_rd_s1;
	logic signed [DIFF_W-1:0]  diff_s2;
	logic [INV_W-1:0]          inv_s2;
	logic signed [VALUE_W-1:0] coef_s2;
	logic signed [PROD_W-1:0]  prod_s3;
	logic signed [VALUE_W-1:0] coef_s3;
	logic signed [VALUE_W-1:0] norm_s4;
	logic signed [VALUE_W-1:0] coef_s4;
	logic signed [TERM_W-1:0]  term_s5;
	logic signed [ACC_W-1:0]   score_s6;
	logic signed [VALUE_W-1:0] clamped_s7;
	logic                      sat_s7;
	logic signed [VALUE_W-1:0] clamped_s8;
	logic                      sat_s8;
	logic [RomAw-1:0]          ti_s8;
	result_t                   out_q;

	logic signed [ACC_W-1:0]   acc_q;
	logic signed [VALUE_W-1:0] bias_q;

	logic signed [PROD_W-1:0]      nbound;
	logic signed [PROD_W-1:0]      shifted;
	logic signed [VALUE_W-1:0]     norm_c;
	logic signed [TERM_PROD_W-1:0] tprod;
	logic signed [ACC_W:0]         base;
	logic signed [ACC_W:0]         sum;
	logic signed [ACC_W-1:0]       acc_next;
	logic signed [ACC_W-1:0]       slim;
	logic signed [ACC_W-1:0]       clamp_full;
	logic                          sat_c;
	logic signed [VALUE_W-1:0]     t_c;
	logic [VALUE_W-1:0]            tp_sum;
	logic [TiProdW-1:0]            ti_full;
	logic [TiProdW-1:0]            ti_shift;

	// The whole pipeline moves together; it holds only while a result waits at the output.
	assign adv          = !out_valid_q || scores.ready;
	assign pop          = cmds.valid && adv;
	assign cmds.ready   = adv;
	assign addr         = AddrW'(cmds.data.index);
	assign scores.valid = out_valid_q;
	assign scores.data  = out_q;

	assign status.busy = valid_s1 || valid_s2 || valid_s3 || valid_s4 || valid_s5
		|| valid_s6 || valid_s7 || valid_s8;
	assign status.result_pending = valid_s6 || valid_s7 || valid_s8;

	// Table write and read share the same stage, so a load is seen by every later sample.
	always_ff @(posedge clk) begin
		if (adv) begin
			if (pop && cmds.data.op == OP_LOAD) begin
				mean_mem[addr] <= cmds.data.mean;
				inv_mem[addr]  <= cmds.data.inv_scale;
				coef_mem[addr] <= cmds.data.weight;
			end
			mean_rd_s1 <= mean_mem[addr];
			inv_rd_s1  <= inv_mem[addr];
			coef_rd_s1 <= coef_mem[addr];
		end
	end

	always_comb begin
		nbound  = PROD_W'($signed({1'b0, normalized_limit, {NORM_SHIFT{1'b0}}}));
		shifted = prod_s3 >>> NORM_SHIFT;
		if (prod_s3 > nbound) begin
			norm_c = VALUE_W'($signed({1'b0, normalized_limit}));
		end else if (prod_s3 < -nbound) begin
			norm_c = -VALUE_W'($signed({1'b0, normalized_limit}));
		end else begin
			norm_c = shifted[VALUE_W-1:0];
		end
	end

	assign tprod = TERM_PROD_W'(norm_s4) * TERM_PROD_W'(coef_s4);

	always_comb begin
		if (tag_s5.first) begin
			base = (ACC_W + 1)'(bias_q);
		end else begin
			base = (ACC_W + 1)'(acc_q);
		end
		sum = base + (ACC_W + 1)'(term_s5);
		if (sum[ACC_W] != sum[ACC_W-1]) begin
			acc_next = sum[ACC_W] ? {1'b1, {(ACC_W - 1){1'b0}}} : {1'b0, {(ACC_W - 1){1'b1}}};
		end else begin
			acc_next = sum[ACC_W-1:0];
		end
	end

	always_comb begin
		slim  = ACC_W'($signed({1'b0, score_limit}));
		sat_c = 1'b1;
		if (score_s6 > slim) begin
			clamp_full = slim;
		end else if (score_s6 < -slim) begin
			clamp_full = -slim;
		end else begin
			clamp_full = score_s6;
			sat_c      = 1'b0;
		end
	end

	always_comb begin
		if (clamped_s7 < HalfNeg) begin
			t_c = HalfNeg;
		end else if (clamped_s7 > HalfTop) begin
			t_c = HalfTop;
		end else begin
			t_c = clamped_s7;
		end
		tp_sum   = t_c + HalfPos;
		ti_full  = TiProdW'(tp_sum[TP_W-1:0]) * TiProdW'(SIGMOID_ENTRIES);
		ti_shift = ti_full >> TP_W;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			valid_s5    <= 1'b0;
			valid_s6    <= 1'b0;
			valid_s7    <= 1'b0;
			valid_s8    <= 1'b0;
			out_valid_q <= 1'b0;
			acc_q       <= '0;
			bias_q      <= '0;
		end else if (adv) begin
			valid_s1    <= pop;
			valid_s2    <= valid_s1 && (tag_s1.op != OP_LOAD);
			valid_s3    <= valid_s2;
			valid_s4    <= valid_s3;
			valid_s5    <= valid_s4;
			valid_s6    <= valid_s5 && (tag_s5.op == OP_SAMPLE) && tag_s5.last;
			valid_s7    <= valid_s6;
			valid_s8    <= valid_s7;
			out_valid_q <= valid_s8;
			if (valid_s5 && tag_s5.op == OP_BIAS) begin
				bias_q <= tag_s5.value;
			end
			if (valid_s5 && tag_s5.op == OP_SAMPLE) begin
				acc_q <= acc_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s1.op       <= cmds.data.op;
			tag_s1.in_range <= cmds.data.in_range;
			tag_s1.first    <= cmds.data.first;
			tag_s1.last     <= cmds.data.last;
			tag_s1.value    <= cmds.data.value;
			tag_s2          <= tag_s1;
			tag_s3          <= tag_s2;
			tag_s4          <= tag_s3;
			tag_s5          <= tag_s4;

			diff_s2 <= DIFF_W'(tag_s1.value) - DIFF_W'(mean_rd_s1);
			inv_s2  <= inv_rd_s1;
			coef_s2 <= coef_rd_s1;

			prod_s3 <= PROD_W'(diff_s2) * PROD_W'($signed({1'b0, inv_s2}));
			coef_s3 <= coef_s2;

			norm_s4 <= norm_c;
			coef_s4 <= coef_s3;

			term_s5 <= tag_s4.in_range ? tprod[TERM_PROD_W-1:NORM_SHIFT] : '0;

			score_s6 <= acc_next;

			clamped_s7 <= clamp_full[VALUE_W-1:0];
			sat_s7     <= sat_c;

			clamped_s8 <= clamped_s7;
			sat_s8     <= sat_s7;
			ti_s8      <= ti_shift[RomAw-1:0];

			if (valid_s8) begin
				out_q.probability     <= SigRom[ti_s8];
				out_q.clamped_score   <= clamped_s8;
				out_q.score_saturated <= sat_s8;
			end
		end
	end
endmodule

FILE: rtl/logistic_regression_scorer.sv
// Top level of the logistic regression scorer: configuration registers and the three parts.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// The scorer takes one request per cycle on samples while its queue has room, and answers
// each feature vector with one request on scores. A request with func 0 loads mean, inverse
// scale and coefficient for one feature index, func 1 loads the bias, func 2 is a feature
// sample and func 3 is ignored. A sample at index 0 restarts the score from the bias; every
// sample within the tables adds the floored product of its clamped standardized value and
// its coefficient, and the sample marked last produces the clamped score, a saturation flag
// and a sigmoid probability. Requests flow at one per cycle while no result waits on scores:
// a front stage classifies them, a four-entry queue decouples it from the back end, and the
// back end is a nine-stage pipeline (table read, subtract, 25x33 multiply, clamp, 24x24
// multiply, accumulate, score clamp, table index, sigmoid ROM read) whose accumulator loop
// sets the one-request-per-cycle rate. The whole back end holds while a result waits on
// scores, and the queue lets the front keep taking samples meanwhile until it fills. The
// coefficient tables are not cleared by reset: every index must be loaded before a sample
// reads it. The sigmoid table is a ROM computed at elaboration, so no start-up pass is needed.
// The configuration channel is always ready; write it only while no vector is in flight.
module logistic_regression_scorer #(
	parameter int MAX_FEATURES    = 256,
	parameter int SIGMOID_ENTRIES = 1024
) (
	input logic         clk,
	input logic         arst_n,
	lrs_stream_if.sink   samples,
	lrs_stream_if.source scores,
	lrs_stream_if.sink   cfg
);
	import lrs_pkg::*;

	logic [LIMIT_W-1:0] normalized_limit_q;
	logic [LIMIT_W-1:0] score_limit_q;
	back_status_t       back_st;

	// Classified requests on their way from the front end into the queue and out to the back.
	lrs_stream_if #(.payload_t(cmd_t)) cmd_push ();
	lrs_stream_if #(.payload_t(cmd_t)) cmd_pop ();

	// Configuration writes land directly in the limit registers.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			normalized_limit_q <= NORM_LIMIT_RESET;
			score_limit_q      <= SCORE_LIMIT_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.data.index)
				CFG_NORMALIZED_LIMIT: normalized_limit_q <= cfg.data.value;
				CFG_SCORE_LIMIT:      score_limit_q      <= cfg.data.value;
			endcase
		end
	end

	lrs_front #(
		.MAX_FEATURES(MAX_FEATURES)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(samples),
		.push   (cmd_push)
	);

	lrs_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (cmd_push),
		.pop   (cmd_pop)
	);

	lrs_back #(
		.MAX_FEATURES   (MAX_FEATURES),
		.SIGMOID_ENTRIES(SIGMOID_ENTRIES)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.normalized_limit(normalized_limit_q),
		.score_limit     (score_limit_q),
		.cmds            (cmd_pop),
		.scores          (scores),
		.status          (back_st)
	);

	// The front refuses a request only because the queue is refusing its held request.
	`ASSERT_SAME_CYCLE(a_front_stall_cause, clk, arst_n, !samples.ready,
		cmd_push.valid && !cmd_push.ready, "front stalled without a queue stall")
	// A request pushed into the queue is visible at its output in the next cycle.
	`ASSERT_NEXT_CYCLE(a_queue_visible, clk, arst_n, cmd_push.valid && cmd_push.ready,
		cmd_pop.valid, "queue lost a pushed request")
	// A request taken by the back end occupies its pipeline in the next cycle.
	`ASSERT_NEXT_CYCLE(a_back_takes, clk, arst_n, cmd_pop.valid && cmd_pop.ready,
		back_st.busy, "back end dropped a request")
	// No result may appear without a vector ending in the result stages.
	`ASSERT_NEXT_CYCLE(a_no_spurious_result, clk, arst_n,
		!back_st.result_pending && !scores.valid, !scores.valid, "result without a vector end")
endmodule

FILE: dv/logistic_regression_scorer_tb.sv
// Self-checking testbench for the logistic regression scorer, with a bit-exact score predictor.
`timescale 1ns / 1ps
module logistic_regression_scorer_tb;
	import lrs_pkg::*;

	// The testbench streams table loads, bias loads and feature vectors into the scorer and
	// predicts every score request in step with the accepted sample requests. The predictor
	// keeps its own copy of the three feature tables, the bias, the 48-bit accumulator and
	// both limits, and it builds its own sigmoid table with the same integer recipe as the
	// hardware ROM. Scores are checked in order, field by field, as they are accepted.

	localparam int     TAB_DEPTH     = 256;
	localparam int     SIG_ENTRIES   = 1024;
	localparam longint HALF_RANGE    = 64'sd2097152;
	localparam longint ACC_MAX       = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint ACC_MIN       = -ACC_MAX - 1;
	localparam int     SETTLE_CYCLES = 32;
	localparam int     TAIL_CYCLES   = 40;
	localparam int     HOLD_CYCLES   = 400;
	localparam int     STALL_LIMIT   = 5000;

	localparam logic signed [VALUE_W-1:0] Q_ONE = 24'sh010000;
	localparam logic signed [VALUE_W-1:0] Q_MAX = 24'sh7FFFFF;
	localparam logic signed [VALUE_W-1:0] Q_MIN = 24'sh800000;

	// Predictor of the scorer. It sees requests in acceptance order, so its table and
	// accumulator contents always match what the hardware uses for the same sample.
	class logit_model;
		logic signed [VALUE_W-1:0] mean_tab [TAB_DEPTH];
		logic [INV_W-1:0]          inv_tab [TAB_DEPTH];
		logic signed [VALUE_W-1:0] coef_tab [TAB_DEPTH];
		logic signed [VALUE_W-1:0] bias;
		longint                    acc;
		logic [LIMIT_W-1:0]        norm_limit;
		logic [LIMIT_W-1:0]        score_limit;
		logic [PROB_W-1:0]         sigmoid_rom [SIG_ENTRIES];
		result_t                   pending_scores[$];
		int                        mismatch_count;

		function new();
			longint          x;
			longint unsigned a;
			longint unsigned e;
			longint unsigned d;
			longint unsigned num;
			longint unsigned p;
			bias           = '0;
			acc            = 0;
			norm_limit     = NORM_LIMIT_RESET;
			score_limit    = SCORE_LIMIT_RESET;
			mismatch_count = 0;
			// Each entry holds the sigmoid at the middle of its slice of -32.0 to +32.0.
			for (int i = 0; i < SIG_ENTRIES; i++) begin
				x   = -HALF_RANGE + ((2 * i + 1) * (2 * HALF_RANGE)) / (2 * SIG_ENTRIES);
				a   = (x < 0) ? -x : x;
				e   = decay_q31(a);
				d   = (64'd1 << 31) + e;
				num = (x > 0) ? (64'd1 << 47) : (e << 16);
				p   = (num + d / 2) / d;
				sigmoid_rom[i] = (p > 65535) ? 16'hFFFF : 16'(p);
			end
		endfunction

		// e^-a with a in Q16 and the result in Q31: a short series on a/256, then eight
		// rounded squarings bring it back to the full exponent.
		function longint unsigned decay_q31(longint unsigned a);
			longint unsigned u;
			longint unsigned u2;
			longint unsigned u3;
			longint unsigned u4;
			longint unsigned r;
			u  = a << 7;
			u2 = (u * u) >> 31;
			u3 = (u2 * u) >> 31;
			u4 = (u3 * u) >> 31;
			r  = ((64'd1 << 31) + u2 / 2 + u4 / 24) - u - u3 / 6;
			for (int k = 0; k < 8; k++) begin
				r = (r * r + (64'd1 << 30)) >> 31;
			end
			return r;
		endfunction

		function void set_limit(cfg_reg_t which, logic [LIMIT_W-1:0] v);
			case (which)
				CFG_NORMALIZED_LIMIT: norm_limit = v;
				CFG_SCORE_LIMIT: score_limit = v;
				default: ;
			endcase
		endfunction

		// Notes one accepted sample request and queues the score it causes, if any.
		function void apply_request(item_t rq);
			logic signed [VALUE_W-1:0] smp;
			logic signed [VALUE_W-1:0] mu;
			logic signed [VALUE_W-1:0] w;
			longint                    diff;
			longint                    inv_l;
			longint                    w_l;
			longint                    prod;
			longint                    lim;
			longint                    norm;
			longint                    term;
			longint                    s;
			longint                    t;
			longint                    slot;
			result_t                   res;
			case (rq.func)
				FUNC_LOAD: begin
					mean_tab[rq.feature_index] = rq.feature_mean;
					inv_tab[rq.feature_index]  = rq.inverse_scale;
					coef_tab[rq.feature_index] = rq.weight;
				end
				FUNC_BIAS: bias = rq.feature_value;
				FUNC_SAMPLE: begin
					smp   = rq.feature_value;
					mu    = mean_tab[rq.feature_index];
					w     = coef_tab[rq.feature_index];
					diff  = smp;
					diff  = diff - mu;
					inv_l = inv_tab[rq.feature_index];
					w_l   = w;
					// Standardize in Q32, clamp there, then floor down to Q16.
					prod  = diff * inv_l;
					lim   = norm_limit;
					if (prod > lim * 65536)
						norm = lim;
					else if (prod < -lim * 65536)
						norm = -lim;
					else
						norm = prod >>> 16;
					term = (norm * w_l) >>> 16;
					if (rq.feature_index == 0)
						acc = bias;
					acc = acc + term;
					if (acc > ACC_MAX)
						acc = ACC_MAX;
					if (acc < ACC_MIN)
						acc = ACC_MIN;
					if (rq.last_feature) begin
						lim                 = score_limit;
						s                   = acc;
						res.score_saturated = 1'b0;
						if (s > lim) begin
							s                   = lim;
							res.score_saturated = 1'b1;
						end else if (s < -lim) begin
							s                   = -lim;
							res.score_saturated = 1'b1;
						end
						// Scores beyond the table range use its end entries.
						t = s;
						if (t < -HALF_RANGE)
							t = -HALF_RANGE;
						if (t > HALF_RANGE - 1)
							t = HALF_RANGE - 1;
						slot = ((t + HALF_RANGE) * SIG_ENTRIES) >>> 22;
						if (slot > SIG_ENTRIES - 1)
							slot = SIG_ENTRIES - 1;
						res.probability   = sigmoid_rom[slot];
						res.clamped_score = 24'(s);
						pending_scores.push_back(res);
					end
				end
				default: ;
			endcase
		endfunction

		// Compares one accepted score request with the oldest prediction.
		function void match_score(result_t got);
			result_t want;
			if (pending_scores.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected score, probability %0d score %0d saturated %0d",
					$time, got.probability, got.clamped_score, got.score_saturated);
				return;
			end
			want = pending_scores.pop_front();
			if (got.probability !== want.probability) begin
				mismatch_count++;
				$display("%0t: probability expected %0d actual %0d", $time,
					want.probability, got.probability);
			end
			if (got.clamped_score !== want.clamped_score) begin
				mismatch_count++;
				$display("%0t: clamped_score expected %0d actual %0d", $time,
					want.clamped_score, got.clamped_score);
			end
			if (got.score_saturated !== want.score_saturated) begin
				mismatch_count++;
				$display("%0t: score_saturated expected %0d actual %0d", $time,
					want.score_saturated, got.score_saturated);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	lrs_stream_if #(.payload_t(item_t))    samples ();
	lrs_stream_if #(.payload_t(result_t))  scores ();
	lrs_stream_if #(.payload_t(cfg_req_t)) cfg ();

	logistic_regression_scorer dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples),
		.scores  (scores),
		.cfg     (cfg)
	);

	logit_model model = new();

	// Indexes whose table entry has been loaded; samples only ever read these, since the
	// tables come out of reset with no defined contents.
	bit          loaded_flag [TAB_DEPTH];
	int unsigned loaded_list[$];
	// While set, sample requests go out back to back with no gaps.
	bit          steady;
	int          scores_taken = 0;
	int          idle_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Random Q7.16 value: mostly modest magnitudes around one, with full-range noise and the
	// field extremes mixed in so every bit toggles.
	function automatic logic signed [VALUE_W-1:0] rand_q7_16();
		int unsigned               k;
		logic signed [VALUE_W-1:0] v;
		case ($urandom_range(0, 9))
			0, 1: v = 24'($urandom);
			2: begin
				case ($urandom_range(0, 3))
					0: v = Q_MAX;
					1: v = Q_MIN;
					2: v = '0;
					default: v = '1;
				endcase
			end
			default: begin
				k = $urandom_range(0, 21);
				v = 24'($urandom & ((32'd1 << k) - 1));
				if ($urandom_range(0, 1))
					v = -v;
			end
		endcase
		return v;
	endfunction

	// Random Q16.16 inverse scale, usually at most four so standardized values stay in range.
	function automatic logic [INV_W-1:0] rand_inverse();
		logic [INV_W-1:0] v;
		case ($urandom_range(0, 9))
			0, 1: v = $urandom;
			2: begin
				case ($urandom_range(0, 2))
					0: v = '0;
					1: v = '1;
					default: v = 32'h0001_0000;
				endcase
			end
			default: v = $urandom_range(0, 32'h0004_0000);
		endcase
		return v;
	endfunction

	// Random clamp bound: a third over the whole field, the rest at most 40.0.
	function automatic logic [LIMIT_W-1:0] rand_limit();
		if ($urandom_range(0, 2) == 0)
			return 23'($urandom);
		return 23'($urandom_range(0, 32'h0028_0000));
	endfunction

	// Gap before a sample request: mostly none, sometimes a short pause, rarely a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 50);
	endfunction

	function automatic int unsigned pick_loaded();
		return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
	endfunction

	function automatic item_t load_item(logic [INDEX_W-1:0] idx,
		logic signed [VALUE_W-1:0] mu, logic [INV_W-1:0] inv,
		logic signed [VALUE_W-1:0] w, bit last);
		item_t rq;
		rq.func          = FUNC_LOAD;
		rq.feature_index = idx;
		rq.feature_value = rand_q7_16();
		rq.feature_mean  = mu;
		rq.inverse_scale = inv;
		rq.weight        = w;
		rq.last_feature  = last;
		return rq;
	endfunction

	// Bias, sample or reserved request; the table fields it does not use carry noise.
	function automatic item_t value_item(func_t f, logic [INDEX_W-1:0] idx,
		logic signed [VALUE_W-1:0] val, bit last);
		item_t rq;
		rq.func          = f;
		rq.feature_index = idx;
		rq.feature_value = val;
		rq.feature_mean  = rand_q7_16();
		rq.inverse_scale = rand_inverse();
		rq.weight        = rand_q7_16();
		rq.last_feature  = last;
		return rq;
	endfunction

	// Offers one sample request and returns at the edge where it is accepted. Valid stays
	// high into the next request unless a gap is wanted, so it is never dropped and raised
	// again within one time step.
	task automatic send_request(input item_t rq);
		int unsigned gap;
		gap = steady ? 0 : pick_gap();
		if (gap != 0) begin
			samples.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		samples.valid <= 1'b1;
		samples.data  <= rq;
		@(posedge clk);
		while (!samples.ready) @(posedge clk);
		model.apply_request(rq);
		if (rq.func == FUNC_LOAD && !loaded_flag[rq.feature_index]) begin
			loaded_flag[rq.feature_index] = 1'b1;
			loaded_list.push_back(32'(rq.feature_index));
		end
	endtask

	// Stops offering samples until every predicted score has come back. Always waits on a clock
	// edge before checking, so the next request never raises valid in the step that lowered it.
	task automatic drain_scores();
		samples.valid <= 1'b0;
		do @(posedge clk); while (model.pending_scores.size() != 0);
	endtask

	// Limits change only with the scorer idle: drained, then a settle time for any trailing
	// samples that cause no score but still update the accumulator.
	task automatic set_limit(input cfg_reg_t which, input logic [LIMIT_W-1:0] v);
		drain_scores();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg.valid      <= 1'b1;
		cfg.data.index <= which;
		cfg.data.value <= v;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		model.set_limit(which, v);
		cfg.valid <= 1'b0;
	endtask

	task automatic program_limits(input logic [LIMIT_W-1:0] norm_lim,
		input logic [LIMIT_W-1:0] score_lim);
		set_limit(CFG_NORMALIZED_LIMIT, norm_lim);
		set_limit(CFG_SCORE_LIMIT, score_lim);
	endtask

	// Directed opening: table entries at the field extremes, a reserved request, loads that
	// carry the last flag, positive and negative score saturation, a single-sample vector,
	// a vector that continues without a fresh start at index zero, and a zero table entry.
	task automatic run_directed();
		send_request(load_item(8'd0, 24'sd0, 32'h0001_0000, Q_ONE, 1'b0));
		send_request(load_item(8'd1, Q_MIN, 32'h0001_0000, Q_MAX, 1'b1));
		send_request(load_item(8'd255, Q_MAX, 32'hFFFF_FFFF, Q_MIN, 1'b0));
		send_request(load_item(8'd2, 24'sd0, 32'd0, 24'sd0, 1'b0));
		send_request(load_item(8'd128, Q_ONE, 32'h0000_8000, -Q_ONE, 1'b0));
		send_request(value_item(FUNC_BIAS, 8'd0, Q_ONE, 1'b1));
		send_request(value_item(FUNC_RESERVED, 8'hFF, Q_MAX, 1'b1));
		send_request(value_item(FUNC_SAMPLE, 8'd0, 24'sh020000, 1'b1));
		send_request(value_item(FUNC_SAMPLE, 8'd0, Q_MAX, 1'b0));
		send_request(value_item(FUNC_SAMPLE, 8'd255, Q_MIN, 1'b0));
		send_request(value_item(FUNC_SAMPLE, 8'd2, Q_MAX, 1'b1));
		send_request(value_item(FUNC_BIAS, 8'd77, Q_MIN, 1'b0));
		send_request(value_item(FUNC_SAMPLE, 8'd0, Q_MIN, 1'b1));
		send_request(value_item(FUNC_BIAS, 8'd0, 24'sd0, 1'b0));
		send_request(value_item(FUNC_SAMPLE, 8'd1, 24'sd0, 1'b0));
		send_request(value_item(FUNC_SAMPLE, 8'd128, 24'sh030000, 1'b1));
		send_request(value_item(FUNC_SAMPLE, 8'd0, -24'sd1, 1'b0));
		send_request(value_item(FUNC_SAMPLE, 8'd128, 24'sd0, 1'b0));
		send_request(value_item(FUNC_SAMPLE, 8'd255, Q_MAX, 1'b1));
		send_request(value_item(FUNC_BIAS, 8'd0, Q_MAX, 1'b0));
		send_request(value_item(FUNC_SAMPLE, 8'd0, 24'sd0, 1'b1));
	endtask

	// Random traffic, mostly complete vectors that start at index zero and end with the
	// last flag, mixed with table reloads, bias updates, reserved requests and stray samples
	// that extend whatever vector is open. Reserved requests do not count toward the quota.
	task automatic stream_random_traffic(input int unsigned quota);
		int unsigned     sent;
		int unsigned     r;
		int unsigned     len;
		logic [INDEX_W-1:0] idx;
		sent = 0;
		while (sent < quota) begin
			if ($urandom_range(0, 19) == 0)
				steady = ~steady;
			r = $urandom_range(0, 99);
			if (r < 8) begin
				idx = INDEX_W'($urandom_range(0, TAB_DEPTH - 1));
				send_request(load_item(idx, rand_q7_16(), rand_inverse(), rand_q7_16(),
					1'($urandom_range(0, 1))));
				sent++;
			end else if (r < 11) begin
				send_request(value_item(FUNC_BIAS, INDEX_W'($urandom_range(0, 255)),
					rand_q7_16(), 1'($urandom_range(0, 1))));
				sent++;
			end else if (r < 13) begin
				send_request(value_item(FUNC_RESERVED, INDEX_W'($urandom_range(0, 255)),
					rand_q7_16(), 1'($urandom_range(0, 1))));
			end else if (r < 16) begin
				send_request(value_item(FUNC_SAMPLE, INDEX_W'(pick_loaded()), rand_q7_16(),
					1'($urandom_range(0, 1))));
				sent++;
			end else begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
				for (int k = 0; k < len; k++) begin
					idx = (k == 0) ? 8'd0 : 8'(pick_loaded());
					send_request(value_item(FUNC_SAMPLE, idx, rand_q7_16(), k == len - 1));
				end
				sent += len;
			end
			if ($urandom_range(0, 149) == 0)
				drain_scores();
		end
	endtask

	// Every accepted score request is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && scores.valid && scores.ready) begin
			model.match_score(scores.data);
			scores_taken++;
		end
	end

	// Ends the run if no request moves on any channel for too long.
	always @(posedge clk) begin
		if ((samples.valid && samples.ready) || (scores.valid && scores.ready) ||
			(cfg.valid && cfg.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Score receiver: random ready with short and long stalls and stretches of steady
	// acceptance. Once, early on, it holds off for a long stretch while samples keep coming,
	// so the queue fills and the scorer pushes back on its sample input.
	initial begin : score_sink
		int unsigned r;
		bit          held;
		held = 1'b0;
		scores.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!held && scores_taken >= 25) begin
				held = 1'b1;
				scores.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 15) begin
					scores.ready <= 1'b1;
					repeat ($urandom_range(50, 200)) @(posedge clk);
				end else if (r < 65) begin
					scores.ready <= 1'b1;
					repeat ($urandom_range(1, 6)) @(posedge clk);
				end else if (r < 95) begin
					scores.ready <= 1'b0;
					repeat ($urandom_range(1, 4)) @(posedge clk);
				end else begin
					scores.ready <= 1'b0;
					repeat ($urandom_range(20, 80)) @(posedge clk);
				end
			end
		end
	end

	initial begin : stimulus
		arst_n         <= 1'b0;
		samples.valid  <= 1'b0;
		samples.data   <= '0;
		cfg.valid      <= 1'b0;
		cfg.data       <= '0;
		steady         = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// First phase runs on the reset limits, with one full pause in the middle.
		run_directed();
		stream_random_traffic(200);
		drain_scores();
		stream_random_traffic(150);

		// Later phases walk through both extremes, random limits and back to the defaults.
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: program_limits(23'd0, 23'd0);
				1: program_limits(23'h7FFFFF, 23'h7FFFFF);
				5: program_limits(NORM_LIMIT_RESET, SCORE_LIMIT_RESET);
				default: program_limits(rand_limit(), rand_limit());
			endcase
			stream_random_traffic((ph == 1) ? 300 : 200);
		end

		drain_scores();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (model.mismatch_count == 0 && model.pending_scores.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
